@@ sv/ftle_pkg.sv @@
// Package for the flow table with lookup and expiry.
// Holds the table size, field widths, operation and status codes and the
// command and status structs between controller and datapath. No dependencies.
package ftle_pkg;

   // Table geometry.
   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

   // Fixed field widths of the channel words.
   localparam int FUNC_W     = 2;
   localparam int ADDR_W     = 32;
   localparam int PORT_W     = 16;
   localparam int TIME_W     = 32;
   localparam int REL_W      = 4;
   localparam int STATUS_W   = 3;
   localparam int RSP_SLOT_W = 4;
   localparam int RSP_CNT_W  = 5;
   localparam int TOTAL_W    = 32;

   // Reset value of the idle timeout in seconds.
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(60);

   // Operation codes carried by req_func.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOOKUP  = 2'd0,
      FUNC_EXPIRE  = 2'd1,
      FUNC_RELEASE = 2'd2
   } func_type;

   // Status codes carried by rsp_status.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT      = 3'd0,
      STATUS_ALLOC    = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_RELEASED = 3'd3,
      STATUS_SWEEP    = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the accepted request word
      logic match_en;  // register the hit and free slot search
      logic apply_en;  // update the table for lookup or release
      logic sweep_en;  // check and advance one slot of the expiry walk
      logic load_rsp;  // move the finished result into the output register
   } ftle_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;  // the walk is at the last slot
      logic rsp_free;    // output register can take a word
   } ftle_sts_type;

endpackage

@@ sv/ftle_ctrl.sv @@
// Controller state machine of the flow table.
// Sequences accept, search, update, expiry walk and result hand-off.
// Depends on ftle_pkg.
module ftle_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [ftle_pkg::FUNC_W-1:0]    req_func,
   output logic                           req_ready,
   input  ftle_pkg::ftle_sts_type         sts,
   output ftle_pkg::ftle_cmd_type         cmd
);
   import ftle_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY,
      ST_SWEEP,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      accept;

   assign accept    = req_valid && req_ready_ff;
   assign req_ready = req_ready_ff;

   // Next state and next ready.
   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_LOOKUP: begin
                     state_in     = ST_MATCH;
                     req_ready_in = 1'b0;
                  end
                  FUNC_EXPIRE: begin
                     state_in     = ST_SWEEP;
                     req_ready_in = 1'b0;
                  end
                  FUNC_RELEASE: begin
                     state_in     = ST_APPLY;
                     req_ready_in = 1'b0;
                  end
                  default: begin
                     // An unused code leaves the table alone and gives no word.
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MATCH: state_in = ST_APPLY;
         ST_APPLY: state_in = ST_DONE;
         ST_SWEEP: begin
            if (sts.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               state_in     = ST_IDLE;
               req_ready_in = 1'b1;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            req_ready_in = 1'b1;
         end
      endcase
   end

   // State and registered ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   // Command decode.
   always_comb begin
      cmd          = '0;
      cmd.capture  = accept;
      cmd.match_en = (state_ff == ST_MATCH);
      cmd.apply_en = (state_ff == ST_APPLY);
      cmd.sweep_en = (state_ff == ST_SWEEP);
      cmd.load_rsp = (state_ff == ST_DONE) && sts.rsp_free;
   end

   // Ready is only offered while idle.
   assert property (@(posedge clock) disable iff (reset)
      req_ready_ff |-> state_ff == ST_IDLE)
      else $error("ready raised outside idle");

   // A word with a used code closes the input until its result is handed off.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == FUNC_LOOKUP || req_func == FUNC_EXPIRE ||
                  req_func == FUNC_RELEASE)) |=> !req_ready_ff)
      else $error("input stayed open after accepting a word");

   // The expiry walk only ends at the last slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && !sts.sweep_last) |=> state_ff == ST_SWEEP)
      else $error("expiry walk left early");

endmodule

@@ sv/ftle_datapath.sv @@
// Datapath of the flow table: slot storage, tuple compare, expiry walk,
// counters, timeout register and output register.
// Depends on ftle_pkg.
module ftle_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ftle_pkg::ftle_cmd_type            cmd,
   output ftle_pkg::ftle_sts_type            sts,
   input  logic [ftle_pkg::FUNC_W-1:0]       req_func,
   input  logic [ftle_pkg::ADDR_W-1:0]       req_src_ip,
   input  logic [ftle_pkg::ADDR_W-1:0]       req_dst_ip,
   input  logic [ftle_pkg::PORT_W-1:0]       req_sport,
   input  logic [ftle_pkg::PORT_W-1:0]       req_dport,
   input  logic [ftle_pkg::TIME_W-1:0]       req_now_seconds,
   input  logic [ftle_pkg::REL_W-1:0]        req_slot_to_release,
   input  logic                              csr_wr_en,
   input  logic [ftle_pkg::TIME_W-1:0]       csr_wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ftle_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ftle_pkg::RSP_SLOT_W-1:0]   rsp_slot,
   output logic [ftle_pkg::RSP_CNT_W-1:0]    rsp_active_count,
   output logic [ftle_pkg::RSP_CNT_W-1:0]    rsp_expired_now,
   output logic [ftle_pkg::TOTAL_W-1:0]      rsp_expired_total
);
   import ftle_pkg::*;

   // Request word held for the duration of the operation.
   logic [FUNC_W-1:0] func_ff;
   logic [ADDR_W-1:0] src_ip_ff, dst_ip_ff;
   logic [PORT_W-1:0] sport_ff, dport_ff;
   logic [TIME_W-1:0] now_ff;
   logic [REL_W-1:0]  rel_ff;

   // Slot storage.
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [ADDR_W-1:0]    ent_src_ip_ff   [NUM_SLOTS];
   logic [ADDR_W-1:0]    ent_dst_ip_ff   [NUM_SLOTS];
   logic [PORT_W-1:0]    ent_sport_ff    [NUM_SLOTS];
   logic [PORT_W-1:0]    ent_dport_ff    [NUM_SLOTS];
   logic [TIME_W-1:0]    ent_last_ff     [NUM_SLOTS];

   // Counters and configuration.
   logic [CNT_W-1:0]   active_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [TIME_W-1:0]  timeout_ff;

   // Search results.
   logic              hit_found_ff, free_found_ff;
   logic [SLOT_W-1:0] hit_idx_ff, free_idx_ff;
   logic              hit_found_in, free_found_in;
   logic [SLOT_W-1:0] hit_idx_in, free_idx_in;

   // Expiry walk.
   logic [SLOT_W-1:0] sweep_idx_ff;
   logic [CNT_W-1:0]  freed_ff;
   logic [TIME_W-1:0] age;
   logic              sweep_expire;

   // Lookup result awaiting hand-off.
   logic [STATUS_W-1:0] look_status_ff;
   logic [SLOT_W-1:0]   look_slot_ff;

   // Release target.
   logic              rel_ok;
   logic [SLOT_W-1:0] rel_idx;

   // Output register.
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [RSP_SLOT_W-1:0] rsp_slot_ff;
   logic [RSP_CNT_W-1:0]  rsp_active_ff;
   logic [RSP_CNT_W-1:0]  rsp_expired_now_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;

   // Timeout register.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // Latch the accepted request word.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff     <= req_func;
         src_ip_ff   <= req_src_ip;
         dst_ip_ff   <= req_dst_ip;
         sport_ff    <= req_sport;
         dport_ff    <= req_dport;
         now_ff      <= req_now_seconds;
         rel_ff      <= req_slot_to_release;
      end
   end

   // Compare the tuple against every slot and find the lowest hit and the
   // lowest free slot. Scanning downward leaves the lowest index in place.
   always_comb begin
      hit_found_in  = 1'b0;
      free_found_in = 1'b0;
      hit_idx_in    = '0;
      free_idx_in   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && ent_src_ip_ff[i] == src_ip_ff &&
             ent_dst_ip_ff[i] == dst_ip_ff && ent_sport_ff[i] == sport_ff &&
             ent_dport_ff[i] == dport_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_found_in = 1'b1;
            free_idx_in   = SLOT_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match_en) begin
         hit_found_ff  <= hit_found_in;
         hit_idx_ff    <= hit_idx_in;
         free_found_ff <= free_found_in;
         free_idx_ff   <= free_idx_in;
      end
   end

   // Release target and the age of the slot under the walk.
   assign rel_ok       = 32'(rel_ff) < 32'(NUM_SLOTS);
   assign rel_idx      = SLOT_W'(rel_ff);
   assign age          = now_ff - ent_last_ff[sweep_idx_ff];
   assign sweep_expire = valid_ff[sweep_idx_ff] && (age >= timeout_ff);

   // Valid bits and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         active_ff <= '0;
         total_ff  <= '0;
      end else if (cmd.apply_en) begin
         if (func_ff == FUNC_LOOKUP) begin
            if (!hit_found_ff && free_found_ff) begin
               valid_ff[free_idx_ff] <= 1'b1;
               active_ff             <= active_ff + CNT_W'(1);
            end
         end else if (func_ff == FUNC_RELEASE) begin
            if (rel_ok && valid_ff[rel_idx]) begin
               valid_ff[rel_idx] <= 1'b0;
               if (active_ff != '0) begin
                  active_ff <= active_ff - CNT_W'(1);
               end
            end
         end
      end else if (cmd.sweep_en && sweep_expire) begin
         valid_ff[sweep_idx_ff] <= 1'b0;
         if (active_ff != '0) begin
            active_ff <= active_ff - CNT_W'(1);
         end
         if (total_ff != '1) begin
            total_ff <= total_ff + TOTAL_W'(1);
         end
      end
   end

   // Slot contents and the lookup result.
   always_ff @(posedge clock) begin
      if (cmd.apply_en && func_ff == FUNC_LOOKUP) begin
         if (hit_found_ff) begin
            ent_last_ff[hit_idx_ff] <= now_ff;
            look_status_ff          <= STATUS_HIT;
            look_slot_ff            <= hit_idx_ff;
         end else if (free_found_ff) begin
            ent_src_ip_ff[free_idx_ff]   <= src_ip_ff;
            ent_dst_ip_ff[free_idx_ff]   <= dst_ip_ff;
            ent_sport_ff[free_idx_ff]    <= sport_ff;
            ent_dport_ff[free_idx_ff]    <= dport_ff;
            ent_last_ff[free_idx_ff]     <= now_ff;
            look_status_ff               <= STATUS_ALLOC;
            look_slot_ff                 <= free_idx_ff;
         end else begin
            look_status_ff <= STATUS_FULL;
            look_slot_ff   <= '0;
         end
      end
   end

   // Expiry walk position and freed count, restarted with each word.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sweep_idx_ff <= '0;
         freed_ff     <= '0;
      end else if (cmd.sweep_en) begin
         sweep_idx_ff <= sweep_idx_ff + SLOT_W'(1);
         if (sweep_expire) begin
            freed_ff <= freed_ff + CNT_W'(1);
         end
      end
   end

   // Output register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_active_ff <= RSP_CNT_W'(active_ff);
         rsp_total_ff  <= total_ff;
         case (func_ff)
            FUNC_LOOKUP: begin
               rsp_status_ff      <= look_status_ff;
               rsp_slot_ff        <= RSP_SLOT_W'(look_slot_ff);
               rsp_expired_now_ff <= '0;
            end
            FUNC_EXPIRE: begin
               rsp_status_ff      <= STATUS_SWEEP;
               rsp_slot_ff        <= '0;
               rsp_expired_now_ff <= RSP_CNT_W'(freed_ff);
            end
            default: begin
               rsp_status_ff      <= STATUS_RELEASED;
               rsp_slot_ff        <= '0;
               rsp_expired_now_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_active_count  = rsp_active_ff;
   assign rsp_expired_now   = rsp_expired_now_ff;
   assign rsp_expired_total = rsp_total_ff;

   // Status to the controller.
   always_comb begin
      sts            = '0;
      sts.sweep_last = (sweep_idx_ff == SLOT_W'(NUM_SLOTS - 1));
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // The active count always equals the number of valid slots.
   assert property (@(posedge clock) disable iff (reset)
      32'(active_ff) == $countones(valid_ff))
      else $error("active count out of step with valid bits");

   // The expired total never goes down.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> total_ff >= $past(total_ff))
      else $error("expired total decreased");

endmodule

@@ sv/flow_table_lookup_expire.sv @@
// Flow table with tuple lookup, allocation, release and timed expiry.
// Top level: joins the controller and the datapath. Depends on ftle_pkg,
// ftle_ctrl and ftle_datapath.
//
// The table holds NUM_SLOTS (16) flows, each a TCP 4-tuple and a last-seen
// time in seconds. A lookup returns the lowest valid slot that matches and
// stamps it with req_now_seconds; on a miss it takes the lowest free slot,
// or reports the table full. An expire sweep frees every valid slot whose
// age (now minus last-seen, modulo 2^32) is at least the timeout written
// through csr_wr_data (60 after reset). A release frees one slot by index.
// Operation code 3 is taken and dropped without a result. One word is in
// work at a time: a lookup compares all slots in parallel, then updates
// the table, then hands off; a release updates, then hands off; a sweep
// runs the expiry walk, which checks one slot per cycle, then hands off.
// A finished result sits in an output register, so the next word is
// accepted as soon as the result is handed to that register, even if
// rsp_ready is low.
module flow_table_lookup_expire (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ftle_pkg::FUNC_W-1:0]       req_func,
   input  logic [ftle_pkg::ADDR_W-1:0]       req_src_ip,
   input  logic [ftle_pkg::ADDR_W-1:0]       req_dst_ip,
   input  logic [ftle_pkg::PORT_W-1:0]       req_sport,
   input  logic [ftle_pkg::PORT_W-1:0]       req_dport,
   input  logic [ftle_pkg::TIME_W-1:0]       req_now_seconds,
   input  logic [ftle_pkg::REL_W-1:0]        req_slot_to_release,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ftle_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ftle_pkg::RSP_SLOT_W-1:0]   rsp_slot,
   output logic [ftle_pkg::RSP_CNT_W-1:0]    rsp_active_count,
   output logic [ftle_pkg::RSP_CNT_W-1:0]    rsp_expired_now,
   output logic [ftle_pkg::TOTAL_W-1:0]      rsp_expired_total,
   input  logic                              csr_wr_en,
   input  logic [ftle_pkg::TIME_W-1:0]       csr_wr_data
);
   import ftle_pkg::*;

   ftle_cmd_type cmd;
   ftle_sts_type sts;

   // Sequencing.
   ftle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage, compare, counters and output register.
   ftle_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_func            (req_func),
      .req_src_ip          (req_src_ip),
      .req_dst_ip          (req_dst_ip),
      .req_sport           (req_sport),
      .req_dport           (req_dport),
      .req_now_seconds     (req_now_seconds),
      .req_slot_to_release (req_slot_to_release),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot            (rsp_slot),
      .rsp_active_count    (rsp_active_count),
      .rsp_expired_now     (rsp_expired_now),
      .rsp_expired_total   (rsp_expired_total)
   );

endmodule

@@ bench/tb_flow_table_lookup_expire.sv @@
// Self-checking testbench for flow_table_lookup_expire: directed and random lookup,
// expire and release words, each checked against a flow table tracked inside the bench.
// Depends on ftle_pkg and the flow_table_lookup_expire RTL.
module tb_flow_table_lookup_expire;
   timeunit 1ns;
   timeprecision 1ps;

   import ftle_pkg::*;

   // Operation code that the block takes and drops without a result.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   // Cycles to let pass once nothing is expected: covers a full sweep and its hand-off.
   localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 8;
   localparam int POOL_SIZE    = 24;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 204;

   typedef struct packed {
      logic [ADDR_W-1:0] src_ip;
      logic [ADDR_W-1:0] dst_ip;
      logic [PORT_W-1:0] sport;
      logic [PORT_W-1:0] dport;
   } flow_tuple_type;

   typedef struct {
      logic [FUNC_W-1:0] func;
      flow_tuple_type    tuple;
      logic [TIME_W-1:0] now;
      logic [REL_W-1:0]  rel;
   } req_word_type;

   typedef struct {
      status_type            status;
      logic [RSP_SLOT_W-1:0] slot;
      logic [RSP_CNT_W-1:0]  active;
      logic [RSP_CNT_W-1:0]  freed;
      logic [TOTAL_W-1:0]    total;
   } rsp_word_type;

   // Tracks the flow table and holds the response words still owed by the block.
   class flow_table_tracker;
      bit                slot_used[NUM_SLOTS];
      flow_tuple_type    slot_tuple[NUM_SLOTS];
      logic [TIME_W-1:0] slot_seen[NUM_SLOTS];
      int unsigned       active_flows;
      logic [TOTAL_W-1:0] expired_sum;
      logic [TIME_W-1:0] timeout;
      rsp_word_type      expected_rsp_q[$];
      int                errors;

      function new();
         int i;
         for (i = 0; i < NUM_SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_tuple[i] = '0;
            slot_seen[i] = '0;
         end
         active_flows = 0;
         expired_sum = '0;
         timeout = TIMEOUT_RESET;
         errors = 0;
      endfunction

      function void set_timeout(logic [TIME_W-1:0] value);
         timeout = value;
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      // Apply one accepted request word to the table and queue its response.
      function void note_request(req_word_type w);
         rsp_word_type r;
         int        i;
         int        hit_idx;
         int        free_idx;
         int        freed;
         hit_idx = -1;
         free_idx = -1;
         freed = 0;
         r.slot = '0;
         r.freed = '0;
         case (w.func)
            FUNC_LOOKUP: begin
               for (i = 0; i < NUM_SLOTS; i++) begin
                  if (hit_idx < 0 && slot_used[i] && slot_tuple[i] == w.tuple)
                     hit_idx = i;
                  if (free_idx < 0 && !slot_used[i])
                     free_idx = i;
               end
               if (hit_idx >= 0) begin
                  slot_seen[hit_idx] = w.now;
                  r.status = STATUS_HIT;
                  r.slot = RSP_SLOT_W'(hit_idx);
               end else if (free_idx >= 0) begin
                  slot_used[free_idx] = 1'b1;
                  slot_tuple[free_idx] = w.tuple;
                  slot_seen[free_idx] = w.now;
                  active_flows++;
                  r.status = STATUS_ALLOC;
                  r.slot = RSP_SLOT_W'(free_idx);
               end else begin
                  r.status = STATUS_FULL;
               end
            end
            FUNC_EXPIRE: begin
               // Age is taken modulo 2^32, so a clock that went back looks very old.
               for (i = 0; i < NUM_SLOTS; i++) begin
                  if (slot_used[i] && TIME_W'(w.now - slot_seen[i]) >= timeout) begin
                     slot_used[i] = 1'b0;
                     if (active_flows > 0)
                        active_flows--;
                     if (expired_sum != '1)
                        expired_sum++;
                     freed++;
                  end
               end
               r.status = STATUS_SWEEP;
               r.freed = RSP_CNT_W'(freed);
            end
            FUNC_RELEASE: begin
               // A release of a free slot changes nothing but is still answered.
               if (w.rel < NUM_SLOTS && slot_used[w.rel]) begin
                  slot_used[w.rel] = 1'b0;
                  if (active_flows > 0)
                     active_flows--;
               end
               r.status = STATUS_RELEASED;
            end
            default: begin
               return;
            end
         endcase
         r.active = RSP_CNT_W'(active_flows);
         r.total = expired_sum;
         expected_rsp_q.push_back(r);
      endfunction

      // Compare one accepted response word with the oldest expectation.
      function void check_response(rsp_word_type got);
         rsp_word_type exp_rsp;
         if (expected_rsp_q.size() == 0) begin
            $error("response word with no request outstanding: status %0d", got.status);
            errors++;
            return;
         end
         exp_rsp = expected_rsp_q.pop_front();
         if (got.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, got.status);
            errors++;
         end
         if (got.slot !== exp_rsp.slot) begin
            $error("slot: expected %0d, actual %0d", exp_rsp.slot, got.slot);
            errors++;
         end
         if (got.active !== exp_rsp.active) begin
            $error("active_count: expected %0d, actual %0d", exp_rsp.active, got.active);
            errors++;
         end
         if (got.freed !== exp_rsp.freed) begin
            $error("expired_now: expected %0d, actual %0d", exp_rsp.freed, got.freed);
            errors++;
         end
         if (got.total !== exp_rsp.total) begin
            $error("expired_total: expected %0d, actual %0d", exp_rsp.total, got.total);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [FUNC_W-1:0]     req_func;
   logic [ADDR_W-1:0]     req_src_ip;
   logic [ADDR_W-1:0]     req_dst_ip;
   logic [PORT_W-1:0]     req_sport;
   logic [PORT_W-1:0]     req_dport;
   logic [TIME_W-1:0]     req_now_seconds;
   logic [REL_W-1:0]      req_slot_to_release;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [RSP_SLOT_W-1:0] rsp_slot;
   logic [RSP_CNT_W-1:0]  rsp_active_count;
   logic [RSP_CNT_W-1:0]  rsp_expired_now;
   logic [TOTAL_W-1:0]    rsp_expired_total;
   logic                  csr_wr_en;
   logic [TIME_W-1:0]     csr_wr_data;

   flow_table_tracker flow_sb = new();
   flow_tuple_type    tuple_pool[POOL_SIZE];
   logic [TIME_W-1:0] clock_now;
   int unsigned       time_step;
   int unsigned       send_idle_pct = 35;
   int unsigned       rsp_stall_pct = 35;

   flow_table_lookup_expire dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_src_ip         (req_src_ip),
      .req_dst_ip         (req_dst_ip),
      .req_sport          (req_sport),
      .req_dport          (req_dport),
      .req_now_seconds    (req_now_seconds),
      .req_slot_to_release(req_slot_to_release),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_active_count   (rsp_active_count),
      .rsp_expired_now    (rsp_expired_now),
      .rsp_expired_total  (rsp_expired_total),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // Clock with a 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Response side stalls at random.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Check every response word accepted by the bench.
   always @(posedge clock) begin
      rsp_word_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = status_type'(rsp_status);
         got.slot = rsp_slot;
         got.active = rsp_active_count;
         got.freed = rsp_expired_now;
         got.total = rsp_expired_total;
         flow_sb.check_response(got);
      end
   end

   // Present one request word, with an optional gap first, and wait for its accept.
   task automatic send_word(input req_word_type w);
      if (1) begin
         @(negedge clock);
         if ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         req_valid = 1'b1;
         req_func = w.func;
         req_src_ip = w.tuple.src_ip;
         req_dst_ip = w.tuple.dst_ip;
         req_sport = w.tuple.sport;
         req_dport = w.tuple.dport;
         req_now_seconds = w.now;
         req_slot_to_release = w.rel;
         do @(posedge clock); while (!req_ready);
         flow_sb.note_request(w);
      end
   endtask

   task automatic send_op(input logic [FUNC_W-1:0] func, input flow_tuple_type tuple,
                          input logic [TIME_W-1:0] now, input logic [REL_W-1:0] rel);
      req_word_type w;
      w.func = func;
      w.tuple = tuple;
      w.now = now;
      w.rel = rel;
      send_word(w);
   endtask

   // Stop sending and wait until every response has come and the block has settled.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (flow_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIME_W-1:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      csr_wr_data = $urandom;
      flow_sb.set_timeout(value);
   endtask

   // Random request word: mostly lookups on a small pool of flows so that hits,
   // allocations and a full table all occur, mixed with sweeps and releases.
   function automatic req_word_type next_random_word();
      req_word_type w;
      int        roll;
      roll = $urandom_range(0, 99);
      w.tuple = {$urandom, $urandom, 16'($urandom), 16'($urandom)};
      w.rel = REL_W'($urandom_range(0, 15));
      clock_now += $urandom_range(0, time_step);
      if ($urandom_range(0, 99) < 2)
         clock_now = $urandom;
      w.now = clock_now;
      if (roll < 58) begin
         w.func = FUNC_LOOKUP;
         if ($urandom_range(0, 99) < 85)
            w.tuple = tuple_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (roll < 72) begin
         w.func = FUNC_EXPIRE;
         // A time just behind a stamp gives an age near 2^32.
         if ($urandom_range(0, 99) < 15)
            w.now = clock_now - $urandom_range(0, 3);
      end else if (roll < 95) begin
         w.func = FUNC_RELEASE;
      end else begin
         w.func = FUNC_UNUSED;
      end
      return w;
   endfunction

   // Main sequence.
   initial begin
      logic [TIME_W-1:0] phase_timeout[PHASE_COUNT];
      int unsigned       phase_step[PHASE_COUNT];
      flow_tuple_type    fill_tuple;
      int                p;
      int                n;
      phase_timeout = '{32'd0, 32'hFFFF_FFFF, 32'd20, 32'd60, 32'd1,
                        32'($urandom_range(5, 200)), 32'($urandom), 32'd100};
      phase_step = '{5, 1, 4, 8, 2, 10, 16, 12};
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_LOOKUP;
      req_src_ip = '0;
      req_dst_ip = '0;
      req_sport = '0;
      req_dport = '0;
      req_now_seconds = '0;
      req_slot_to_release = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      for (n = 0; n < POOL_SIZE; n++)
         tuple_pool[n] = {$urandom, $urandom, 16'($urandom), 16'($urandom)};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words under the reset timeout of 60.
      send_op(FUNC_LOOKUP, '0, 32'd0, '0);
      send_op(FUNC_LOOKUP, '1, 32'hFFFF_FFFF, '1);
      send_op(FUNC_LOOKUP, '0, 32'd5, '0);
      send_op(FUNC_RELEASE, '0, 32'd6, 4'd15);
      send_op(FUNC_RELEASE, '0, 32'd7, 4'd1);
      // Age one below the timeout stays, age equal to it is expired.
      send_op(FUNC_EXPIRE, '0, 32'd64, '0);
      send_op(FUNC_EXPIRE, '0, 32'd65, '0);
      send_op(FUNC_UNUSED, '1, 32'd66, '1);
      // Fill every slot, then one more lookup finds the table full.
      for (n = 0; n <= NUM_SLOTS; n++) begin
         fill_tuple = {32'h0A00_0000 | n, ~32'(n), 16'(n), 16'hFFFF - 16'(n)};
         send_op(FUNC_LOOKUP, fill_tuple, 32'd100 + n, '0);
      end

      // Random phases, each under its own timeout, written while the block is idle.
      for (p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         write_timeout(phase_timeout[p]);
         time_step = phase_step[p];
         clock_now = (p == 1) ? 32'hFFFF_FF00 : $urandom;
         send_idle_pct = (p == 1) ? 0 : 35;
         rsp_stall_pct = (p == 1) ? 0 : 35;
         for (n = 0; n < PHASE_ITEMS; n++)
            send_word(next_random_word());
      end

      wait_drained();
      if (flow_sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ flow_table_lookup_expire.f @@
sv/ftle_pkg.sv
sv/ftle_ctrl.sv
sv/ftle_datapath.sv
sv/flow_table_lookup_expire.sv
bench/tb_flow_table_lookup_expire.sv
